FILE: sv/tmis_pkg.sv
// Shared constants, types and helpers for the trimmed-mean interval smoother.
package tmis_pkg;

  localparam int unsigned SampleBits    = 16;
  localparam int unsigned WindowDefault = 11;
  localparam int unsigned TrimDefault   = 2;
  // 0.016 s in 16-bit fractional seconds, rounded to nearest
  localparam int unsigned ResetInterval = (16 * (1 << SampleBits) + 500) / 1000;

  typedef logic [SampleBits-1:0] sample_t;

  typedef struct packed {
    logic clr;      // start a new pass over the history
    logic smp_vld;  // history word present on the read data
    logic fin;      // form the kept sum
  } rank_ctrl_t;

  // Per-side trim, limited so at least one entry is averaged.
  function automatic int unsigned eff_trim(input int unsigned window,
                                           input int unsigned trim);
    int unsigned max_trim;
    max_trim = (window - 1) >> 1;
    return (trim < max_trim) ? trim : max_trim;
  endfunction

endpackage

FILE: sv/tmis_hist_mem.sv
// History memory: one write port, one registered read port, reset-value valid bits.
module tmis_hist_mem #(
  parameter int unsigned DEPTH = tmis_pkg::WindowDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         we_i,
  input  logic [$clog2(DEPTH)-1:0]     waddr_i,
  input  tmis_pkg::sample_t            wdata_i,
  input  logic                         re_i,
  input  logic [$clog2(DEPTH)-1:0]     raddr_i,
  output tmis_pkg::sample_t            rdata_o
);
  import tmis_pkg::*;

  sample_t            mem_q [DEPTH];
  logic [DEPTH-1:0]   valid_q;
  sample_t            rd_q;
  logic               rd_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q       <= mem_q[raddr_i];
      rd_valid_q <= valid_q[raddr_i];
    end
  end

  // An entry never written reads as the reset interval.
  assign rdata_o = rd_valid_q ? rd_q : sample_t'(ResetInterval);

endmodule

FILE: sv/tmis_rank.sv
// Running total plus largest and smallest trackers; yields the trimmed sum.
module tmis_rank #(
  parameter int unsigned WINDOW = tmis_pkg::WindowDefault,
  parameter int unsigned TRIM   = tmis_pkg::TrimDefault
) (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  tmis_pkg::rank_ctrl_t                               ctrl_i,
  input  tmis_pkg::sample_t                                  smp_i,
  output logic [tmis_pkg::SampleBits+$clog2(WINDOW)-1:0]     kept_sum_o
);
  import tmis_pkg::*;

  localparam int unsigned EffTrim = eff_trim(WINDOW, TRIM);
  localparam int unsigned TrimN   = (EffTrim > 0) ? EffTrim : 1;
  localparam int unsigned SumW    = SampleBits + $clog2(WINDOW);

  // top_q descending, bot_q ascending
  logic [TrimN-1:0][SampleBits-1:0] top_q, top_d, bot_q, bot_d;
  logic [TrimN-1:0]                 gt, lt;
  logic [SumW-1:0]                  total_q, total_d, kept_q, kept_d, trim_sum;
  logic                             busy_q;

  always_comb begin
    top_d    = top_q;
    bot_d    = bot_q;
    total_d  = total_q;
    kept_d   = kept_q;
    trim_sum = '0;
    for (int i = 0; i < TrimN; i++) begin
      gt[i] = smp_i > top_q[i];
      lt[i] = smp_i < bot_q[i];
      trim_sum = trim_sum + SumW'(top_q[i]) + SumW'(bot_q[i]);
    end
    if (EffTrim == 0) begin
      trim_sum = '0;
    end
    if (ctrl_i.clr) begin
      top_d   = '0;
      bot_d   = '1;
      total_d = '0;
    end else if (ctrl_i.smp_vld) begin
      total_d = total_q + SumW'(smp_i);
      // insert: shift smaller (larger) entries down one place
      if (gt[0]) top_d[0] = smp_i;
      if (lt[0]) bot_d[0] = smp_i;
      for (int i = 1; i < TrimN; i++) begin
        if (gt[i]) top_d[i] = gt[i-1] ? top_q[i-1] : smp_i;
        if (lt[i]) bot_d[i] = lt[i-1] ? bot_q[i-1] : smp_i;
      end
    end
    if (ctrl_i.fin) begin
      kept_d = total_q - trim_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (ctrl_i.clr) begin
      busy_q <= 1'b1;
    end else if (ctrl_i.fin) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q   <= top_d;
    bot_q   <= bot_d;
    total_q <= total_d;
    if (busy_q) begin
      kept_q <= kept_d;
    end
  end

  assign kept_sum_o = kept_q;

endmodule

FILE: sv/trimmed_mean_interval_smoother.sv
// Top level: sequencer over the history memory, constant divide and blend.
//
//   channel | handshake                | payload
//   --------+--------------------------+------------------------------------
//   in      | in_valid_i / in_ready_o  | frame_time_i
//   out     | out_valid_o / out_ready_i| smoothed_interval_o, trimmed_mean_o
//
// Words are taken only in the idle state: the walk reads one history entry per
// cycle through the single read port, then the last read drains, trim, divide,
// multiply and blend follow in turn, and the idle state takes the next word, so
// a new word is not taken before the last one is through blend. in_ready_o is
// high only while idle; the finished word sits in an output register, so a new
// word is taken while the last result waits downstream, and blend holds while
// that register is full and not being read.
// Reset restores the history to 0.016 s at once through per-entry valid bits.
module trimmed_mean_interval_smoother #(
  parameter int unsigned WINDOW = tmis_pkg::WindowDefault,
  parameter int unsigned TRIM   = tmis_pkg::TrimDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tmis_pkg::sample_t  frame_time_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tmis_pkg::sample_t  smoothed_interval_o,
  output tmis_pkg::sample_t  trimmed_mean_o
);
  import tmis_pkg::*;

  localparam int unsigned AddrW    = $clog2(WINDOW);
  localparam int unsigned SumW     = SampleBits + $clog2(WINDOW);
  localparam int unsigned EffTrim  = eff_trim(WINDOW, TRIM);
  localparam int unsigned Kept     = WINDOW - 2 * EffTrim;
  localparam int unsigned DivShift = SumW + $clog2(Kept);
  localparam int unsigned MulW     = SumW + 1;
  localparam int unsigned ProdW    = SumW + MulW;
  // round-up reciprocal: exact floor(n / Kept) for any SumW-bit n
  localparam longint unsigned DivMul =
    ((64'd1 << DivShift) + 64'(Kept) - 64'd1) / 64'(Kept);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DRAIN, S_TRIM, S_DIV, S_MUL, S_BLEND
  } state_e;

  state_e                  state_q;
  logic [AddrW-1:0]        slot_q, addr_q;
  logic                    rd_vld_q;
  sample_t                 sample_q, prior_q, mean_q;
  logic [ProdW-1:0]        prod_q;
  logic [2*SampleBits-1:0] mag_q;
  logic                    neg_q;
  logic                    out_valid_q;
  sample_t                 smoothed_q, tmean_q;

  logic                    accept, mem_we, rd_en, load_out;
  sample_t                 rd_data, mean_w, diff_w, result;
  logic [SampleBits:0]     step_w;
  logic [SumW-1:0]         kept_sum;
  rank_ctrl_t              rank_ctrl;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign mem_we     = accept;
  assign rd_en      = (state_q == S_SCAN);

  tmis_hist_mem #(
    .DEPTH (WINDOW)
  ) u_hist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (slot_q),
    .wdata_i (frame_time_i),
    .re_i    (rd_en),
    .raddr_i (addr_q),
    .rdata_o (rd_data)
  );

  assign rank_ctrl.clr     = accept;
  assign rank_ctrl.smp_vld = rd_vld_q;
  assign rank_ctrl.fin     = (state_q == S_TRIM);

  tmis_rank #(
    .WINDOW (WINDOW),
    .TRIM   (TRIM)
  ) u_rank (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (rank_ctrl),
    .smp_i      (rd_data),
    .kept_sum_o (kept_sum)
  );

  // Mean falls out of the reciprocal product; blend toward it.
  assign mean_w = prod_q[DivShift +: SampleBits];
  assign diff_w = (mean_w < prior_q) ? (prior_q - mean_w) : (mean_w - prior_q);
  // round the magnitude up when moving down, so the blend floors
  assign step_w = {1'b0, mag_q[2*SampleBits-1:SampleBits]} +
                  (SampleBits+1)'(neg_q && (mag_q[SampleBits-1:0] != '0));
  assign result = neg_q ? SampleBits'({1'b0, prior_q} - step_w)
                        : SampleBits'({1'b0, prior_q} + step_w);
  assign load_out = (state_q == S_BLEND) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      slot_q      <= '0;
      addr_q      <= '0;
      rd_vld_q    <= 1'b0;
      prior_q     <= sample_t'(ResetInterval);
      out_valid_q <= 1'b0;
    end else begin
      rd_vld_q <= rd_en;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            slot_q  <= (slot_q == AddrW'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
            addr_q  <= '0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          addr_q <= addr_q + 1'b1;
          if (addr_q == AddrW'(WINDOW - 1)) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: state_q <= S_TRIM;
        S_TRIM:  state_q <= S_DIV;
        S_DIV:   state_q <= S_MUL;
        S_MUL:   state_q <= S_BLEND;
        S_BLEND: begin
          // hold until the output register frees up
          if (load_out) begin
            prior_q <= result;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= frame_time_i;
    end
    if (state_q == S_DIV) begin
      prod_q <= ProdW'(kept_sum) * ProdW'(MulW'(DivMul));
    end
    if (state_q == S_MUL) begin
      mean_q <= mean_w;
      neg_q  <= mean_w < prior_q;
      mag_q  <= (2*SampleBits)'(diff_w) * (2*SampleBits)'(sample_q);
    end
    if (load_out) begin
      smoothed_q <= result;
      tmean_q    <= mean_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign smoothed_interval_o = smoothed_q;
  assign trimmed_mean_o      = tmean_q;

  // The blended value lies between the prior and the mean.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (neg_q ? (result >= mean_q && result <= prior_q)
                        : (result >= prior_q && result <= mean_q)))
    else $error("blend left the prior-to-mean interval");

  // The prior moves only when a result is committed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(prior_q) |-> $past(load_out))
    else $error("prior changed outside the blend commit");

  // The history walk never overlaps a write.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && rd_en))
    else $error("history read and write in the same cycle");

  // Taking a word starts a fresh history walk.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_SCAN && addr_q == '0 && !rd_vld_q))
    else $error("history walk did not start cleanly");

endmodule
